// ===== rtl/htd_pkg.sv =====
// htd_pkg: widths, function and register codes, and the structs used by
// the front, queue and back of the huffman tile decoder
// no dependencies
`default_nettype none

package htd_pkg;

    localparam int FUNC_W     = 2;
    localparam int ADDR_W     = 10;
    localparam int BYTE_W     = 8;
    localparam int OFFS_W     = 14;
    localparam int COL_W      = 9;
    localparam int ROW_W      = 8;
    localparam int X_W        = 10;
    localparam int Y_W        = 9;
    localparam int LEN_W      = 11;
    localparam int LINE_W     = 9;
    localparam int ROWEND_W   = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int REM_W      = 6;
    localparam int QUEUE_DEPTH = 4;

    // item functions
    localparam logic [FUNC_W-1:0] FUNC_BOOK = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SEG  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DATA = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CODEBOOK_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_END        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_END         = 2'd2;

    localparam logic [LEN_W-1:0]    LEN_RESET     = 11'd1024;
    localparam logic [LINE_W-1:0]   LINE_RESET    = 9'd264;
    localparam logic [ROWEND_W-1:0] ROWEND_RESET  = 9'd256;

    // codebook leaf flags
    localparam logic [BYTE_W-1:0] LEAF_ONE  = 8'h01;
    localparam logic [BYTE_W-1:0] LEAF_ZERO = 8'h02;

    localparam logic [X_W-1:0] PIX_STEP = 10'd8;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] value;
        logic [X_W-1:0]    sx;
        logic [Y_W-1:0]    sy;
    } t_cmd;

    typedef struct packed {
        logic [BYTE_W-1:0] pixel;
        logic [COL_W-1:0]  column;
        logic [ROW_W-1:0]  row;
        logic              frame_done;
    } t_pix;

    typedef struct packed {
        logic [LEN_W-1:0]    len;
        logic [LINE_W-1:0]   line_end;
        logic [ROWEND_W-1:0] row_end;
    } t_cfg;

endpackage

`default_nettype wire

// ===== rtl/htd_front.sv =====
// htd_front: input stage of the huffman tile decoder; takes items, drops
// unused function codes and splits the segment offset into column and row
// depends on htd_pkg
`default_nettype none

module htd_front #(
    parameter int ROW_BYTES = 33
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [htd_pkg::FUNC_W-1:0]  i_func,
    input  logic [htd_pkg::ADDR_W-1:0]  i_book_address,
    input  logic [htd_pkg::BYTE_W-1:0]  i_byte_value,
    input  logic [htd_pkg::OFFS_W-1:0]  i_segment_offset,
    input  logic                        i_full,
    output logic                        o_push,
    output htd_pkg::t_cmd               o_cmd
);
    import htd_pkg::*;

    // reciprocal division, exact for every offset of OFFS_W bits
    localparam int     SHIFT_L = $clog2(ROW_BYTES);
    localparam int     SHIFT   = OFFS_W + SHIFT_L;
    localparam int     RECIP_W = OFFS_W + 2;
    localparam int     PROD_W  = OFFS_W + RECIP_W;
    localparam longint RECIP   =
        ((longint'(1) << SHIFT) + longint'(ROW_BYTES) - 1) / longint'(ROW_BYTES);
    localparam int     QD_W    = OFFS_W + 7;

    logic                r_v;
    logic [FUNC_W-1:0]   r_func;
    logic [ADDR_W-1:0]   r_addr;
    logic [BYTE_W-1:0]   r_value;
    logic [OFFS_W-1:0]   r_offs;
    logic [OFFS_W-1:0]   r_q;

    logic                adv;
    logic [PROD_W-1:0]   prod;
    logic [PROD_W-1:0]   prod_sh;
    logic [QD_W-1:0]     qd;
    logic [QD_W-1:0]     rem_full;
    logic [REM_W-1:0]    rem;

    assign adv        = !r_v || !i_full;
    assign o_in_stall = r_v && i_full;

    assign prod    = PROD_W'(i_segment_offset) * PROD_W'(RECIP);
    assign prod_sh = prod >> SHIFT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (adv) begin
            r_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && i_in_valid) begin
            r_func  <= i_func;
            r_addr  <= i_book_address;
            r_value <= i_byte_value;
            r_offs  <= i_segment_offset;
            r_q     <= prod_sh[OFFS_W-1:0];
        end
    end

    // remainder from the registered quotient
    assign qd       = QD_W'(r_q) * QD_W'(ROW_BYTES);
    assign rem_full = QD_W'(r_offs) - qd;
    assign rem      = rem_full[REM_W-1:0];

    assign o_push = r_v && !i_full &&
                    (r_func == FUNC_BOOK || r_func == FUNC_SEG || r_func == FUNC_DATA);

    always_comb begin
        o_cmd.func  = r_func;
        o_cmd.addr  = r_addr;
        o_cmd.value = r_value;
        o_cmd.sx    = X_W'({rem, 3'b000});
        o_cmd.sy    = r_q[Y_W-1:0];
    end

endmodule

`default_nettype wire

// ===== rtl/htd_queue.sv =====
// htd_queue: short command queue between the front and the back of the
// huffman tile decoder
// depends on htd_pkg
`default_nettype none

module htd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  htd_pkg::t_cmd i_cmd,
    output logic          o_full,
    output logic          o_valid,
    output htd_pkg::t_cmd o_cmd,
    input  logic          i_pop
);
    import htd_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;

    logic do_pop;

    assign o_full  = r_cnt == CNT_W'(QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_cmd   = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/htd_back.sv =====
// htd_back: codebook table, bit walker, cursor, result hold and output
// register of the huffman tile decoder
// depends on htd_pkg
`default_nettype none

module htd_back #(
    parameter int BOOK_DEPTH = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  htd_pkg::t_cfg              i_cfg,
    input  logic                       i_cmd_valid,
    input  htd_pkg::t_cmd              i_cmd,
    output logic                       o_pop,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [htd_pkg::BYTE_W-1:0] o_pixel_byte,
    output logic [htd_pkg::COL_W-1:0]  o_column,
    output logic [htd_pkg::ROW_W-1:0]  o_row,
    output logic                       o_frame_done,
    output logic                       o_last_of_run
);
    import htd_pkg::*;

    localparam int IW = $clog2(BOOK_DEPTH);
    localparam int NW = ((IW > 8) ? IW : 8) + 1;
    localparam int LW = (NW > LEN_W) ? NW : LEN_W;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WALK = 1'b1;

    logic [BYTE_W-1:0] r_book [BOOK_DEPTH];

    logic              r_state;
    logic [3:0]        r_k;
    logic [IW-1:0]     r_idx;
    logic              r_prev_leaf;
    logic [X_W-1:0]    r_x;
    logic [Y_W-1:0]    r_y;
    logic              r_dead;
    logic              r_fdone;
    logic              r_pv;
    logic              r_pclosed;
    logic              r_ov;
    logic              r_olast;
    logic [BYTE_W-1:0] r_byte;
    logic [BYTE_W-1:0] r_cur;
    logic [BYTE_W-1:0] r_book0;
    logic [BYTE_W-1:0] r_rdata;
    t_pix              r_pend;
    t_pix              r_out;

    logic              idle;
    logic              walking;
    logic              live;
    logic              out_ready;
    logic              emit;
    logic              walk_adv;
    logic              start_bit;
    logic              bit_v;
    logic [BYTE_W-1:0] cur;
    logic              leaf;
    logic [BYTE_W-1:0] jump;
    logic [LW-1:0]     next;
    logic [LW-1:0]     lim;
    logic              abandon;
    logic [X_W-1:0]    x8;
    logic [Y_W-1:0]    y1;
    logic              wrap;
    logic              done;
    logic              last_bit;
    logic              walk_bit;
    logic              proc;
    logic              start_end;
    logic              walk_end;
    logic              cand;
    t_pix              cand_pix;
    logic              drain;
    logic              push;
    logic              rd_en;
    logic [IW-1:0]     rd_addr;
    logic              wr_ok;
    logic              wr_en;
    logic [IW-1:0]     wr_addr;

    assign idle      = r_state == ST_IDLE;
    assign walking   = r_state == ST_WALK;
    assign live      = !r_dead && !r_fdone;
    assign out_ready = !r_ov || !i_out_stall;
    assign emit      = walking && r_prev_leaf;
    assign walk_adv  = walking && (!(emit && r_pv) || out_ready);
    assign o_pop     = idle && i_cmd_valid;
    assign start_bit = o_pop && i_cmd.func == FUNC_DATA && live;

    // one codebook step; after a leaf the walk restarts on entry zero
    assign bit_v = idle ? i_cmd.value[0] : r_byte[r_k[2:0]];
    assign cur   = idle ? r_cur : (r_prev_leaf ? r_book0 : r_rdata);
    assign leaf  = |(cur & (bit_v ? LEAF_ONE : LEAF_ZERO));
    assign jump  = bit_v ? 8'd1 : (BYTE_W'({cur[7:2], 1'b0}) + 8'd2);
    assign next  = LW'(r_idx) + LW'(jump);
    assign lim   = (LW'(i_cfg.len) < LW'(BOOK_DEPTH)) ? LW'(i_cfg.len) : LW'(BOOK_DEPTH);
    assign abandon = next >= lim;

    // cursor advance for the pixel byte read by the previous step
    assign x8   = r_x + PIX_STEP;
    assign wrap = x8 >= X_W'(i_cfg.line_end);
    assign y1   = r_y + 1'b1;
    assign done = emit && wrap && (y1 >= i_cfg.row_end);

    assign last_bit  = r_k == 4'd8;
    assign walk_bit  = walk_adv && !done && !last_bit;
    assign proc      = start_bit || walk_bit;
    assign start_end = start_bit && abandon;
    assign walk_end  = walk_adv && (done || last_bit || abandon);

    assign cand = walk_adv && emit;
    always_comb begin
        cand_pix.pixel      = ~r_rdata;
        cand_pix.column     = r_x[COL_W-1:0];
        cand_pix.row        = r_y[ROW_W-1:0];
        cand_pix.frame_done = done;
    end

    // a held result leaves once a later one arrives or its byte has ended
    assign drain = !cand && r_pv && r_pclosed && out_ready;
    assign push  = (cand && r_pv) || drain;

    assign rd_en   = proc && !abandon;
    assign rd_addr = next[IW-1:0];
    assign wr_ok   = 32'(i_cmd.addr) < BOOK_DEPTH;
    assign wr_en   = o_pop && i_cmd.func == FUNC_BOOK && wr_ok;
    assign wr_addr = IW'(i_cmd.addr);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_book[wr_addr] <= i_cmd.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= r_book[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_k         <= 4'd0;
            r_idx       <= '0;
            r_prev_leaf <= 1'b0;
            r_x         <= '0;
            r_y         <= '0;
            r_dead      <= 1'b0;
            r_fdone     <= 1'b0;
            r_pv        <= 1'b0;
            r_pclosed   <= 1'b0;
            r_ov        <= 1'b0;
        end else begin
            if (o_pop) begin
                unique case (i_cmd.func)
                    FUNC_SEG: begin
                        r_x     <= i_cmd.sx;
                        r_y     <= i_cmd.sy;
                        r_idx   <= '0;
                        r_dead  <= 1'b0;
                        r_fdone <= 1'b0;
                    end
                    FUNC_DATA: begin
                        if (live) begin
                            if (abandon) begin
                                r_dead <= 1'b1;
                                r_idx  <= '0;
                            end else begin
                                r_idx       <= leaf ? '0 : next[IW-1:0];
                                r_prev_leaf <= leaf;
                                r_k         <= 4'd1;
                                r_state     <= ST_WALK;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end

            if (walk_adv) begin
                if (emit) begin
                    r_x <= wrap ? '0 : x8;
                    r_y <= wrap ? y1 : r_y;
                end
                priority if (done) begin
                    r_fdone <= 1'b1;
                    r_state <= ST_IDLE;
                end else if (last_bit) begin
                    r_state <= ST_IDLE;
                end else if (abandon) begin
                    r_dead  <= 1'b1;
                    r_idx   <= '0;
                    r_state <= ST_IDLE;
                end else begin
                    r_idx       <= leaf ? '0 : next[IW-1:0];
                    r_prev_leaf <= leaf;
                    r_k         <= r_k + 1'b1;
                end
            end

            if (cand) begin
                r_pv      <= 1'b1;
                r_pclosed <= walk_end;
            end else if (drain) begin
                r_pv <= 1'b0;
            end else if (start_end || walk_end) begin
                r_pclosed <= 1'b1;
            end

            if (out_ready) begin
                r_ov <= push;
            end
        end
    end

    // r_cur mirrors the table entry at r_idx, r_book0 mirrors entry zero
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            if (i_cmd.addr == '0) begin
                r_book0 <= i_cmd.value;
            end
            if (32'(i_cmd.addr) == 32'(r_idx)) begin
                r_cur <= i_cmd.value;
            end
        end
        if (o_pop && i_cmd.func == FUNC_SEG) begin
            r_cur <= r_book0;
        end
        if (start_end) begin
            r_cur <= r_book0;
        end
        if (start_bit) begin
            r_byte <= i_cmd.value;
        end
        if (walk_adv) begin
            if (done || (!last_bit && abandon)) begin
                r_cur <= r_book0;
            end else if (last_bit) begin
                r_cur <= r_prev_leaf ? r_book0 : r_rdata;
            end
        end
        if (cand) begin
            r_pend <= cand_pix;
        end
        if (out_ready && push) begin
            r_out   <= r_pend;
            r_olast <= r_pclosed;
        end
    end

    assign o_out_valid   = r_ov;
    assign o_pixel_byte  = r_out.pixel;
    assign o_column      = r_out.column;
    assign o_row         = r_out.row;
    assign o_frame_done  = r_out.frame_done;
    assign o_last_of_run = r_olast;

`ifndef SYNTHESIS
    a_idle_pend_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && r_pv) |-> r_pclosed)
        else $error("open result held while walker idle");

    a_walk_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> (!r_dead && !r_fdone))
        else $error("walking a dead segment or finished frame");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> (r_k != 4'd0 && r_k <= 4'd8))
        else $error("bit step out of range");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_done) |-> o_last_of_run)
        else $error("frame completion not marked as last of run");
`endif

endmodule

`default_nettype wire

// ===== rtl/huffman_tile_decoder.sv =====
// huffman_tile_decoder: a front stage and a four-entry queue feed a back that walks one data
// byte a bit per cycle through the single read port of the codebook table, pausing while a
// result waits on a stalled output; a live data byte holds the back until its last bit, or
// less long when it kills the segment or ends the frame; other items are handled on their pop
// a result is held until the next leaf arrives or its byte has ended
// synchronous reset clears the control state; codebook contents stay undefined, no clear pass
`default_nettype none

module huffman_tile_decoder #(
    parameter int BOOK_DEPTH = 1024,
    parameter int ROW_BYTES  = 33
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [htd_pkg::FUNC_W-1:0]     i_func,
    input  logic [htd_pkg::ADDR_W-1:0]     i_book_address,
    input  logic [htd_pkg::BYTE_W-1:0]     i_byte_value,
    input  logic [htd_pkg::OFFS_W-1:0]     i_segment_offset,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [htd_pkg::BYTE_W-1:0]     o_pixel_byte,
    output logic [htd_pkg::COL_W-1:0]      o_column,
    output logic [htd_pkg::ROW_W-1:0]      o_row,
    output logic                           o_frame_done,
    output logic                           o_last_of_run,
    input  logic                           i_cfg_we,
    input  logic [htd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [htd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import htd_pkg::*;

    t_cfg r_cfg;
    logic q_full;
    logic push;
    t_cmd push_cmd;
    logic head_valid;
    t_cmd head_cmd;
    logic pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.len      <= LEN_RESET;
            r_cfg.line_end <= LINE_RESET;
            r_cfg.row_end  <= ROWEND_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CODEBOOK_LENGTH: r_cfg.len      <= i_cfg_data[LEN_W-1:0];
                CFG_LINE_END:        r_cfg.line_end <= i_cfg_data[LINE_W-1:0];
                CFG_ROW_END:         r_cfg.row_end  <= i_cfg_data[ROWEND_W-1:0];
                default: begin
                end
            endcase
        end
    end

    htd_front #(
        .ROW_BYTES (ROW_BYTES)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_func           (i_func),
        .i_book_address   (i_book_address),
        .i_byte_value     (i_byte_value),
        .i_segment_offset (i_segment_offset),
        .i_full           (q_full),
        .o_push           (push),
        .o_cmd            (push_cmd)
    );

    htd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .o_valid (head_valid),
        .o_cmd   (head_cmd),
        .i_pop   (pop)
    );

    htd_back #(
        .BOOK_DEPTH (BOOK_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_cmd_valid   (head_valid),
        .i_cmd         (head_cmd),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_pixel_byte  (o_pixel_byte),
        .o_column      (o_column),
        .o_row         (o_row),
        .o_frame_done  (o_frame_done),
        .o_last_of_run (o_last_of_run)
    );

endmodule

`default_nettype wire
